### rtl/core/dda_pkg.sv
// Shared widths, types and codes for the DDA line rasteriser.
`timescale 1ns / 1ps

package dda_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  // Accumulator: sign, spare integer bit, COORD_BITS integer, FRAC_BITS fraction
  localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;
  // Increment: signed, magnitude up to 1.0
  localparam int INC_W = FRAC_BITS + 2;
  // Quotient magnitude, one integer bit and FRAC_BITS fraction bits
  localparam int QUO_W = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  localparam int IN_DATA_W  = ((4 * COORD_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 1 + 7) / 8) * 8;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_t;

  typedef struct packed {
    logic                  go;
    logic [COORD_BITS-1:0] mag;
    logic [COORD_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

### rtl/core/dda_div.sv
// Restoring divider: (mag << FRAC_BITS) / den, one quotient bit per cycle.
`timescale 1ns / 1ps

module dda_div (
  input  logic              clk,
  input  logic              rst,
  input  dda_pkg::div_req_t req,
  output dda_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [dda_pkg::CNT_W-1:0]      cnt;
  logic [dda_pkg::COORD_BITS:0]   rem;
  logic [dda_pkg::COORD_BITS-1:0] den;
  logic [dda_pkg::QUO_W-1:0]      quo;

  logic [dda_pkg::COORD_BITS+1:0] diff;
  logic                           fits;
  logic [dda_pkg::COORD_BITS:0]   rem_sub;
  logic [dda_pkg::COORD_BITS:0]   rem_next;

  // mag <= den, so the first compare yields the integer bit and the
  // remainder stays below den from then on
  assign diff     = {1'b0, rem} - {2'b00, den};
  assign fits     = !diff[dda_pkg::COORD_BITS+1];
  assign rem_sub  = fits ? diff[dda_pkg::COORD_BITS:0] : rem;
  assign rem_next = {rem_sub[dda_pkg::COORD_BITS-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= {1'b0, req.mag};
        den  <= req.den;
        quo  <= '0;
      end else if (busy) begin
        quo <= {quo[dda_pkg::QUO_W-2:0], fits};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == dda_pkg::CNT_W'(dda_pkg::FRAC_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

### rtl/core/dda_line_rasterizer.sv
// Top level of the DDA line rasteriser: sequencer, accumulators and output register.
`timescale 1ns / 1ps

// Channel    Dir   Words
// s_axis     in    load (tuser=0) or step (tuser=1) request
// m_axis     out   one pixel per request; tlast marks the final pixel
//
// A step word is taken and its pixel registered in the same cycle, so steps run at
// one pixel per clock while the output side keeps up.
// A load with a non-zero length gives its first pixel once both divisions are
// done: the shared divider iterates one quotient bit per cycle, 17 bits per axis,
// x then y, with a registered hand-over after each axis.
// A zero-length load's pixel is registered in the same cycle that the load is taken.
// s_axis_tready is low during a load's division and while an unread pixel
// sits in the output register with m_axis_tready low.
// rst is synchronous, active high; afterwards no line is active.

module dda_line_rasterizer (
  input  logic                           clk,
  input  logic                           rst,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_x, start_y, end_x, end_y, ink (lowest bit up), zero padded
  input  logic [dda_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic                           s_axis_tuser,

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_x, pixel_y, pixel_ink (lowest bit up), zero padded
  output logic [dda_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  // no_line
  output logic                           m_axis_tuser
);

  localparam int C = dda_pkg::COORD_BITS;
  localparam int F = dda_pkg::FRAC_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y
  } state_t;

  state_t state;

  // line state
  logic signed [dda_pkg::ACC_W-1:0] acc_x, acc_y;
  logic signed [dda_pkg::INC_W-1:0] inc_x, inc_y;
  logic [C-1:0]                     pixels_left;
  logic                             line_active;
  logic                             held_ink;

  // held across the division
  logic [C-1:0] steps;
  logic [C-1:0] mag_y;
  logic         neg_x, neg_y;

  // output register
  logic         out_valid;
  logic [C-1:0] out_x, out_y;
  logic         out_ink, out_last, out_no_line;

  dda_pkg::div_req_t div_req;
  dda_pkg::div_rsp_t div_rsp;

  // input word fields
  logic         in_acc;
  logic [C-1:0] sx, sy, ex, ey;
  logic         in_ink;

  assign sx     = s_axis_tdata[C-1:0];
  assign sy     = s_axis_tdata[2*C-1:C];
  assign ex     = s_axis_tdata[3*C-1:2*C];
  assign ey     = s_axis_tdata[4*C-1:3*C];
  assign in_ink = s_axis_tdata[4*C];

  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // differences, magnitudes and step count
  logic signed [C:0] dx, dy;
  logic [C:0]        dx_neg, dy_neg;
  logic [C-1:0]      ax, ay, steps_in;

  assign dx       = $signed({1'b0, ex}) - $signed({1'b0, sx});
  assign dy       = $signed({1'b0, ey}) - $signed({1'b0, sy});
  assign dx_neg   = -dx;
  assign dy_neg   = -dy;
  assign ax       = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
  assign ay       = dy[C] ? dy_neg[C-1:0] : dy[C-1:0];
  assign steps_in = (ax > ay) ? ax : ay;

  logic load_go;
  assign load_go = in_acc && (dda_pkg::func_t'(s_axis_tuser) == dda_pkg::FUNC_LOAD)
                   && (steps_in != '0);

  // x division starts with the load word, y division when x is done
  always_comb begin
    div_req.go  = 1'b0;
    div_req.mag = ax;
    div_req.den = steps_in;
    if (load_go) begin
      div_req.go = 1'b1;
    end else if (state == S_DIV_X) begin
      div_req.go  = div_rsp.done;
      div_req.mag = mag_y;
      div_req.den = steps;
    end
  end

  dda_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // signed increment from the quotient
  logic [dda_pkg::INC_W-1:0] quo_pos;
  logic [dda_pkg::INC_W-1:0] quo_neg;
  assign quo_pos = {1'b0, div_rsp.quo};
  assign quo_neg = -quo_pos;

  // next accumulators for a step
  logic signed [dda_pkg::ACC_W-1:0] acc_x_sum, acc_y_sum;
  assign acc_x_sum = acc_x + {{(dda_pkg::ACC_W-dda_pkg::INC_W){inc_x[dda_pkg::INC_W-1]}}, inc_x};
  assign acc_y_sum = acc_y + {{(dda_pkg::ACC_W-dda_pkg::INC_W){inc_y[dda_pkg::INC_W-1]}}, inc_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      line_active <= 1'b0;
      pixels_left <= '0;
      held_ink    <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (dda_pkg::func_t'(s_axis_tuser) == dda_pkg::FUNC_LOAD) begin
              acc_x       <= {2'b00, sx, F'(0)};
              acc_y       <= {2'b00, sy, F'(0)};
              held_ink    <= in_ink;
              pixels_left <= steps_in;
              line_active <= (steps_in != '0);
              steps       <= steps_in;
              mag_y       <= ay;
              neg_x       <= dx[C];
              neg_y       <= dy[C];
              if (steps_in == '0) begin
                // zero-length line: single pixel, no division
                inc_x       <= '0;
                inc_y       <= '0;
                out_valid   <= 1'b1;
                out_x       <= sx;
                out_y       <= sy;
                out_ink     <= in_ink;
                out_last    <= 1'b1;
                out_no_line <= 1'b0;
              end else begin
                state <= S_DIV_X;
              end
            end else if (!line_active) begin
              out_valid   <= 1'b1;
              out_x       <= '0;
              out_y       <= '0;
              out_ink     <= 1'b0;
              out_last    <= 1'b0;
              out_no_line <= 1'b1;
            end else begin
              acc_x       <= acc_x_sum;
              acc_y       <= acc_y_sum;
              pixels_left <= pixels_left - 1'b1;
              line_active <= (pixels_left != C'(1));
              out_valid   <= 1'b1;
              out_x       <= acc_x_sum[F +: C];
              out_y       <= acc_y_sum[F +: C];
              out_ink     <= held_ink;
              out_last    <= (pixels_left == C'(1));
              out_no_line <= 1'b0;
            end
          end
        end
        S_DIV_X: begin
          if (div_rsp.done) begin
            inc_x <= neg_x ? quo_neg : quo_pos;
            state <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_rsp.done) begin
            inc_y       <= neg_y ? quo_neg : quo_pos;
            state       <= S_IDLE;
            // first pixel is the start point
            out_valid   <= 1'b1;
            out_x       <= acc_x[F +: C];
            out_y       <= acc_y[F +: C];
            out_ink     <= held_ink;
            out_last    <= 1'b0;
            out_no_line <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(dda_pkg::OUT_DATA_W - 2*C - 1)'(0), out_ink, out_y, out_x};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_no_line;

  // no pixel waits while a division is under way
  a_div_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid)
    else $error("output register busy during division");

  // an active line always has pixels left
  a_active_left: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (pixels_left != '0))
    else $error("active line with no pixels left");

  // divider only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV_X || state == S_DIV_Y))
    else $error("divider done outside division");

  // a step on an active line consumes exactly one pixel
  a_step_count: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tuser && line_active) |=>
      (pixels_left == $past(pixels_left) - 1'b1))
    else $error("pixel count not decremented on step");

endmodule

### sim/dda_line_rasterizer_tb.sv
// Self-checking testbench for the DDA line rasteriser: directed lines, then random line traffic.
`timescale 1ns / 1ps

module dda_line_rasterizer_tb;
  import dda_pkg::*;

  // Run ceiling in clocks
  localparam int RUN_LIMIT   = 1_000_000;
  // Rough number of request words to send before the run winds down
  localparam int TOTAL_WORDS = 1650;
  // Cycles to keep watching once every pixel is in (load latency plus margin)
  localparam int TAIL_CYCLES = 60;

  // One pixel word as the block should return it
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  ink;
    logic                  last;
    logic                  no_line;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;

  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  dda_line_rasterizer dut (.*);

  always #6 clk = ~clk;

  // Shadow of the line being drawn; no line after reset
  logic signed [ACC_W-1:0] line_acc_x = '0, line_acc_y = '0;
  logic signed [INC_W-1:0] line_inc_x = '0, line_inc_y = '0;
  int                      line_left = 0;
  logic                    line_on = 1'b0;
  logic                    line_ink = 1'b0;

  pixel_t pixel_q[$];       // pixels owed by the block, oldest first
  int     sent_words = 0;
  int     mismatches = 0;
  int     pixels_seen = 0;
  int     cycles = 0;
  logic   steady = 1'b0;    // set: neither side starts a new idle gap

  // Per-axis increment, truncated toward zero
  function automatic logic signed [INC_W-1:0] step_inc(int d, int span);
    int q;
    if (span == 0) return '0;
    q = ((d < 0 ? -d : d) << FRAC_BITS) / span;
    return INC_W'(d < 0 ? -q : q);
  endfunction

  // Advances the shadow line by one request word and returns the pixel it yields
  function automatic pixel_t next_pixel(func_t op, logic [COORD_BITS-1:0] sx,
                                        logic [COORD_BITS-1:0] sy,
                                        logic [COORD_BITS-1:0] ex,
                                        logic [COORD_BITS-1:0] ey, logic ink);
    pixel_t                  r;
    int                      dx, dy, span;
    logic signed [ACC_W-1:0] fx, fy;
    r = '0;
    if (op == FUNC_LOAD) begin
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      span = (dx < 0 ? -dx : dx);
      if ((dy < 0 ? -dy : dy) > span) span = (dy < 0 ? -dy : dy);
      line_inc_x = step_inc(dx, span);
      line_inc_y = step_inc(dy, span);
      line_acc_x = ACC_W'(sx) << FRAC_BITS;
      line_acc_y = ACC_W'(sy) << FRAC_BITS;
      line_ink   = ink;
      line_left  = span;
      line_on    = (span != 0);
      r.last     = (span == 0);
    end else if (!line_on) begin
      // stray step: flag only, shadow untouched
      r.no_line = 1'b1;
      return r;
    end else begin
      line_acc_x = line_acc_x + line_inc_x;
      line_acc_y = line_acc_y + line_inc_y;
      line_left  = line_left - 1;
      line_on    = (line_left != 0);
      r.last     = !line_on;
    end
    // arithmetic shift floors, negative or not
    fx = line_acc_x >>> FRAC_BITS;
    fy = line_acc_y >>> FRAC_BITS;
    r.x   = fx[COORD_BITS-1:0];
    r.y   = fy[COORD_BITS-1:0];
    r.ink = line_ink;
    return r;
  endfunction

  // Idle length: none while steady, else mostly none or short, now and then a long one
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one request word after a random gap and holds it until taken
  task automatic send_word(func_t op, logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                           logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey, logic ink);
    int gap;
    gap = idle_gap();
    repeat (gap) @(negedge clk) s_axis_tvalid <= 1'b0;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'({ink, ey, ex, sy, sx});
    do @(posedge clk); while (!s_axis_tready);
    pixel_q.push_back(next_pixel(op, sx, sy, ex, ey, ink));
    sent_words++;
  endtask

  // Step words carry random payload, which the block must ignore
  task automatic send_steps(int n);
    repeat (n)
      send_word(FUNC_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Withdraws the last word, then holds off the sender until every owed pixel is back
  task automatic wait_drained();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] pixel %0d %s: expected %0d, got %0d", $realtime, pixels_seen, what,
               want, got);
  endtask

  // Output side stalls: random start, random length, no new one while steady
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_gap();
    end
  end

  // Pixel checker: every word taken on the output is held against the oldest owed pixel
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        flag_mismatch("arrived with none owed", 0, 1);
      end else begin
        want = pixel_q.pop_front();
        if (m_axis_tdata[COORD_BITS-1:0] !== want.x)
          flag_mismatch("pixel_x", want.x, m_axis_tdata[COORD_BITS-1:0]);
        if (m_axis_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y)
          flag_mismatch("pixel_y", want.y, m_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
        if (m_axis_tdata[2*COORD_BITS] !== want.ink)
          flag_mismatch("pixel_ink", want.ink, m_axis_tdata[2*COORD_BITS]);
        if (m_axis_tlast !== want.last)
          flag_mismatch("last", want.last, m_axis_tlast);
        if (m_axis_tuser !== want.no_line)
          flag_mismatch("no_line", want.no_line, m_axis_tuser);
      end
      pixels_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Nothing loaded yet: a step must come back flagged
  task automatic test_step_without_line();
    send_steps(1);
  endtask

  // Single-pixel line at the far corner; the step after it finds no line
  task automatic test_zero_length();
    send_word(FUNC_LOAD, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1);
    send_steps(1);
  endtask

  // Full-span anti-diagonal cut short by a fresh load, which then runs past its end
  task automatic test_load_replaces_line();
    send_word(FUNC_LOAD, 10'd1023, 10'd0, 10'd0, 10'd1023, 1'b1);
    send_steps(3);
    send_word(FUNC_LOAD, 10'd0, 10'd0, 10'd5, 10'd2, 1'b0);
    send_steps(6);
  endtask

  // Steep line heading up and to the right
  task automatic test_steep_line();
    send_word(FUNC_LOAD, 10'd10, 10'd7, 10'd12, 10'd3, 1'b1);
    send_steps(4);
  endtask

  // Mostly complete lines of random shape; some cut short, overrun, or stray steps
  task automatic test_random_lines();
    int kind, len, dmaj, dmin, dx, dy, sx, sy, n;
    while (sent_words < TOTAL_WORDS) begin
      steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_steps($urandom_range(1, 3));
      end else begin
        n = $urandom_range(0, 99);
        if (n < 70)      len = $urandom_range(0, 12);
        else if (n < 94) len = $urandom_range(13, 80);
        else             len = $urandom_range(81, 1023);
        dmaj = $urandom_range(0, 1) ? len : -len;
        dmin = int'($urandom_range(0, 2 * len)) - len;
        if ($urandom_range(0, 1)) begin
          dx = dmaj;
          dy = dmin;
        end else begin
          dx = dmin;
          dy = dmaj;
        end
        sx = $urandom_range(dx < 0 ? -dx : 0, dx > 0 ? 1023 - dx : 1023);
        sy = $urandom_range(dy < 0 ? -dy : 0, dy > 0 ? 1023 - dy : 1023);
        send_word(FUNC_LOAD, sx, sy, sx + dx, sy + dy, $urandom);
        n = len;
        // long lines are mostly abandoned early to keep the run short
        if (len > 80 && $urandom_range(0, 3) != 0) n = $urandom_range(0, 60);
        else if (kind < 20) n = len + $urandom_range(1, 2);
        else if (kind < 30) n = $urandom_range(0, len);
        send_steps(n);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_step_without_line();
    test_zero_length();
    wait_drained();
    test_load_replaces_line();
    test_steep_line();
    wait_drained();
    test_random_lines();

    @(negedge clk) s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += pixel_q.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/dda_pkg.sv
rtl/core/dda_div.sv
rtl/core/dda_line_rasterizer.sv
sim/dda_line_rasterizer_tb.sv
